// ----- hw/rtl/nnsp_pkg.sv -----
// Shared types, constants and the pixel packing function for the
// nearest-neighbor scaler. No dependencies.
package nnsp_pkg;

   // Fixed field and register widths
   localparam int CFG_DIM_W  = 13;
   localparam int RATIO_W    = 28;
   localparam int ACC_W      = 40;
   localparam int BASE_W     = 24;
   localparam int PIX_W      = 24;
   localparam int COORD_W    = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 28;

   localparam logic [BASE_W-1:0] BASE_MAX = {BASE_W{1'b1}};

   // Request command codes
   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_EMIT    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DST_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DST_HEIGHT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RATIO_X      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RATIO_Y      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HAS_ALPHA    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd6;

   // Pixel formats
   localparam logic [1:0] FMT_RGB555 = 2'd0;
   localparam logic [1:0] FMT_RGB565 = 2'd1;
   localparam logic [1:0] FMT_RGB888 = 2'd2;

   localparam logic [PIX_W-1:0] MASK_R555 = 24'h007c00;
   localparam logic [PIX_W-1:0] MASK_G555 = 24'h0003e0;
   localparam logic [PIX_W-1:0] MASK_R565 = 24'h00f800;
   localparam logic [PIX_W-1:0] MASK_G565 = 24'h0007e0;
   localparam logic [PIX_W-1:0] MASK_B5   = 24'h00001f;
   localparam logic [PIX_W-1:0] MASK_R888 = 24'hff0000;
   localparam logic [PIX_W-1:0] MASK_G888 = 24'h00ff00;
   localparam logic [PIX_W-1:0] MASK_B888 = 24'h0000ff;

   localparam logic [7:0] ALPHA_THRESH = 8'd127;

   // Controller to datapath commands
   typedef struct packed {
      logic mem_write;
      logic restart;
      logic mul_load;
      logic addr_load;
      logic out_load;
   } nnsp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;
   } nnsp_status_type;

   function automatic logic [PIX_W-1:0] pack_pixel(input logic [1:0] fmt,
                                                   input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b);
      logic [PIX_W-1:0] rr;
      logic [PIX_W-1:0] gg;
      logic [PIX_W-1:0] bb;
      rr = PIX_W'(r);
      gg = PIX_W'(g);
      bb = PIX_W'(b);
      case (fmt)
         FMT_RGB555: pack_pixel = ((rr << 7) & MASK_R555) | ((gg << 2) & MASK_G555) |
                                  ((bb >> 3) & MASK_B5);
         FMT_RGB565: pack_pixel = ((rr << 8) & MASK_R565) | ((gg << 3) & MASK_G565) |
                                  ((bb >> 3) & MASK_B5);
         FMT_RGB888: pack_pixel = ((rr << 16) & MASK_R888) | ((gg << 8) & MASK_G888) |
                                  (bb & MASK_B888);
         default:    pack_pixel = '0;
      endcase
   endfunction

endpackage

// ----- hw/rtl/nearest_neighbor_scaler_pixel_pack.sv -----
// Top level of the nearest-neighbor scaler with pixel packing.
// Depends on nnsp_pkg, nnsp_ctrl, nnsp_datapath (which holds nnsp_ram).
//
// The block keeps a source image of RGBA pixels in an internal store and
// produces a scaled destination image one pixel per emit request, in raster
// order, column fastest. Each request is one transfer on the req_ channel:
// a write command stores one pixel at req_src_index (writes past the store
// are dropped), a restart command returns to the top-left corner, and an
// emit command produces exactly one transfer on the rsp_ channel. The source
// pixel is picked by nearest-neighbor stepping: two accumulators advance by
// ratio_x and ratio_y (fixed point with FRAC_BITS fraction bits), the row
// start is floor(y_accum) * src_width saturated to 24 bits, and a source
// index past the store clamps to the last entry and flags range_error. The
// word is packed as RGB555, RGB565 or RGB888 (zero for the unknown format)
// with a solid-mask bit for alpha above 127 when has_alpha is set. Write and
// restart complete on acceptance; an emit steps through accept with the
// source-row multiply, address add and store read, a wait for the
// registered read data, and pack into the output register, as set by the
// sequencer walking the single multiplier and the registered store read
// port; the pack waits while the output register is still held by rsp_stall.
// A finished result may sit in the output register while the next request
// is accepted. Reading a store entry never written since reset gives an
// undefined pixel. Write the csr_ registers only while idle.
module nearest_neighbor_scaler_pixel_pack
   import nnsp_pkg::*;
#(
   parameter int MEM_DEPTH = 65536,
   parameter int MAX_DIM   = 4096,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_cmd,
   input  logic [15:0]           req_src_index,
   input  logic [7:0]            req_red,
   input  logic [7:0]            req_green,
   input  logic [7:0]            req_blue,
   input  logic [7:0]            req_alpha,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_packed_pixel,
   output logic                  rsp_mask_solid,
   output logic [COORD_W-1:0]    rsp_column,
   output logic [COORD_W-1:0]    rsp_row,
   output logic                  rsp_last,
   output logic                  rsp_range_error
);

   nnsp_cmd_type    cmd;
   nnsp_status_type status;

   // Sequencer: decode accepted requests, step the emit sequence
   nnsp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_cmd  (req_cmd),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   // Datapath: registers, DDA position, store and output register
   nnsp_datapath #(
      .MEM_DEPTH(MEM_DEPTH),
      .MAX_DIM  (MAX_DIM),
      .FRAC_BITS(FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_src_index   (req_src_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_alpha       (req_alpha),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_pixel(rsp_packed_pixel),
      .rsp_mask_solid  (rsp_mask_solid),
      .rsp_column      (rsp_column),
      .rsp_row         (rsp_row),
      .rsp_last        (rsp_last),
      .rsp_range_error (rsp_range_error)
   );

endmodule

// ----- hw/rtl/nnsp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nnsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/nnsp_ctrl.sv -----
// Sequencer for the scaler: accepts requests and steps the datapath
// through multiply, address/read and pack. Depends on nnsp_pkg.
module nnsp_ctrl
   import nnsp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [1:0]      req_cmd,
   output logic            req_stall,
   input  nnsp_status_type status,
   output nnsp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_ADDR = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_WRITE:   cmd.mem_write = 1'b1;
                  CMD_RESTART: cmd.restart = 1'b1;
                  CMD_EMIT: begin
                     cmd.mul_load = 1'b1;
                     state_in     = ST_MUL;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            cmd.addr_load = 1'b1;
            state_in      = ST_ADDR;
         end
         ST_ADDR: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold the read word until the output register frees up
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

   a_mul_to_addr: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |=> state_ff == ST_ADDR)
      else $error("multiply stage did not advance to address stage");

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_write |-> state_ff == ST_IDLE && !cmd.out_load)
      else $error("store write outside idle");

   a_emit_enters_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_load |=> state_ff == ST_MUL && req_stall)
      else $error("emit did not start the sequence");

endmodule

// ----- hw/rtl/nnsp_datapath.sv -----
// Datapath of the scaler: configuration registers, position and DDA
// accumulators, source index calculation, pixel store and output register.
// Depends on nnsp_pkg and nnsp_ram.
module nnsp_datapath
   import nnsp_pkg::*;
#(
   parameter int MEM_DEPTH = 65536,
   parameter int MAX_DIM   = 4096,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic [15:0]           req_src_index,
   input  logic [7:0]            req_red,
   input  logic [7:0]            req_green,
   input  logic [7:0]            req_blue,
   input  logic [7:0]            req_alpha,
   input  nnsp_cmd_type          cmd,
   output nnsp_status_type       status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_packed_pixel,
   output logic                  rsp_mask_solid,
   output logic [COORD_W-1:0]    rsp_column,
   output logic [COORD_W-1:0]    rsp_row,
   output logic                  rsp_last,
   output logic                  rsp_range_error
);

   localparam int AW     = $clog2(MEM_DEPTH);
   localparam int XI_W   = ACC_W - FRAC_BITS;
   localparam int PW     = XI_W + CFG_DIM_W;
   localparam int IDX_W  = ((XI_W > BASE_W) ? XI_W : BASE_W) + 1;
   localparam int WCW    = (AW > 16) ? AW + 1 : 17;
   localparam int DIM_W  = ($clog2(MAX_DIM) + 1 > CFG_DIM_W) ? $clog2(MAX_DIM) + 1
                                                             : CFG_DIM_W;

   // configuration
   logic [CFG_DIM_W-1:0] src_width_ff, dst_width_ff, dst_height_ff;
   logic [RATIO_W-1:0]   ratio_x_ff, ratio_y_ff;
   logic                 has_alpha_ff;
   logic [1:0]           pixel_format_ff;

   // position and accumulators
   logic [COORD_W-1:0]   out_x_ff, out_y_ff;
   logic [ACC_W-1:0]     x_accum_ff, y_accum_ff;

   // sequence registers
   logic [PW-1:0]        product_ff;
   logic                 err_ff;

   // output register
   logic                 rsp_valid_ff;
   logic [PIX_W-1:0]     packed_ff;
   logic                 mask_ff;
   logic [COORD_W-1:0]   column_ff, row_ff;
   logic                 last_ff;
   logic                 range_err_ff;

   logic [XI_W-1:0]      x_int, y_int;
   logic [BASE_W-1:0]    row_base;
   logic [IDX_W-1:0]     src_idx;
   logic                 idx_over;
   logic [AW-1:0]        rd_addr;
   logic [WCW-1:0]       wr_ext;
   logic                 wr_en;
   logic [31:0]          rd_word;
   logic [DIM_W-1:0]     w_raw, h_raw, w_eff, h_eff, x_plus, y_plus;
   logic                 end_row, end_frame;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff    <= CFG_DIM_W'(1);
         dst_width_ff    <= CFG_DIM_W'(1);
         dst_height_ff   <= CFG_DIM_W'(1);
         ratio_x_ff      <= RATIO_W'(65536);
         ratio_y_ff      <= RATIO_W'(65536);
         has_alpha_ff    <= 1'b0;
         pixel_format_ff <= FMT_RGB888;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_SRC_WIDTH:    src_width_ff    <= csr_write_data[CFG_DIM_W-1:0];
            REG_DST_WIDTH:    dst_width_ff    <= csr_write_data[CFG_DIM_W-1:0];
            REG_DST_HEIGHT:   dst_height_ff   <= csr_write_data[CFG_DIM_W-1:0];
            REG_RATIO_X:      ratio_x_ff      <= csr_write_data[RATIO_W-1:0];
            REG_RATIO_Y:      ratio_y_ff      <= csr_write_data[RATIO_W-1:0];
            REG_HAS_ALPHA:    has_alpha_ff    <= csr_write_data[0];
            REG_PIXEL_FORMAT: pixel_format_ff <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   // Source index: multiply, then clamp and add
   assign x_int = x_accum_ff[ACC_W-1:FRAC_BITS];
   assign y_int = y_accum_ff[ACC_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         product_ff <= PW'(y_int) * PW'(src_width_ff);
      end
      if (cmd.addr_load) begin
         err_ff <= idx_over;
      end
   end

   assign row_base = (product_ff > PW'(BASE_MAX)) ? BASE_MAX : product_ff[BASE_W-1:0];
   assign src_idx  = IDX_W'(row_base) + IDX_W'(x_int);
   assign idx_over = (src_idx >= IDX_W'(MEM_DEPTH));
   assign rd_addr  = idx_over ? AW'(MEM_DEPTH - 1) : src_idx[AW-1:0];

   // Store writes past the end are dropped
   assign wr_ext = WCW'(req_src_index);
   assign wr_en  = cmd.mem_write && (wr_ext < WCW'(MEM_DEPTH));

   nnsp_ram #(
      .WIDTH(32),
      .DEPTH(MEM_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_ext[AW-1:0]),
      .wr_data({req_red, req_green, req_blue, req_alpha}),
      .rd_en  (cmd.addr_load),
      .rd_addr(rd_addr),
      .rd_data(rd_word)
   );

   // Raster position advance
   assign w_raw = DIM_W'(dst_width_ff);
   assign h_raw = DIM_W'(dst_height_ff);
   assign w_eff = (w_raw == '0) ? DIM_W'(1) :
                  (w_raw > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : w_raw;
   assign h_eff = (h_raw == '0) ? DIM_W'(1) :
                  (h_raw > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : h_raw;
   assign x_plus    = DIM_W'(out_x_ff) + DIM_W'(1);
   assign y_plus    = DIM_W'(out_y_ff) + DIM_W'(1);
   assign end_row   = (x_plus >= w_eff);
   assign end_frame = end_row && (y_plus >= h_eff);

   always_ff @(posedge clock) begin
      if (reset || cmd.restart || (cmd.out_load && end_frame)) begin
         out_x_ff   <= '0;
         out_y_ff   <= '0;
         x_accum_ff <= '0;
         y_accum_ff <= '0;
      end else if (cmd.out_load) begin
         if (!end_row) begin
            out_x_ff   <= x_plus[COORD_W-1:0];
            x_accum_ff <= x_accum_ff + ACC_W'(ratio_x_ff);
         end else begin
            out_x_ff   <= '0;
            x_accum_ff <= '0;
            out_y_ff   <= y_plus[COORD_W-1:0];
            y_accum_ff <= y_accum_ff + ACC_W'(ratio_y_ff);
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         packed_ff    <= pack_pixel(pixel_format_ff, rd_word[31:24], rd_word[23:16],
                                    rd_word[15:8]);
         mask_ff      <= has_alpha_ff && (rd_word[7:0] > ALPHA_THRESH);
         column_ff    <= out_x_ff;
         row_ff       <= out_y_ff;
         last_ff      <= end_frame;
         range_err_ff <= err_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_packed_pixel = packed_ff;
   assign rsp_mask_solid   = mask_ff;
   assign rsp_column       = column_ff;
   assign rsp_row          = row_ff;
   assign rsp_last         = last_ff;
   assign rsp_range_error  = range_err_ff;

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result load did not raise valid");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result overwritten while stalled");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.restart |=> out_x_ff == '0 && out_y_ff == '0 && x_accum_ff == '0)
      else $error("restart did not clear position");

endmodule
